@@ hw/rtl/flpst_pkg.sv @@
// ----------------------------------------------------------------------------
// flpst_pkg
// Shared constants, types and helpers of the flash log parameter store.
// ----------------------------------------------------------------------------
`default_nettype none
package flpst_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);
    localparam int MAX_WORDS  = 128;
    localparam int CB_AW      = $clog2(MAX_WORDS);

    localparam logic [63:0] SLOT_ERASED = '1;
    localparam logic [63:0] SLOT_DEAD   = '0;

    // Request from the sequencer to the slot memory.
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic                 clear_all;
        logic [SLOT_AW-1:0]   addr;
        logic [63:0]          wdata;
    } t_slot_req;

    // One result item.
    typedef struct packed {
        logic        compacted;
        logic        appended;
        logic [31:0] read_data;
        logic        status;
    } t_result;

    function automatic logic slot_consistent(input logic [63:0] v);
        return (~v[63:48]) == v[47:32];
    endfunction

    function automatic logic [31:0] lane_mask(input logic [3:0] m);
        return {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/flpst_slot_mem.sv @@
// ----------------------------------------------------------------------------
// flpst_slot_mem
// Flash page of 64-bit slots with registered read and per-slot valid bits;
// a slot that is not valid reads as erased.
// ----------------------------------------------------------------------------
`default_nettype none
module flpst_slot_mem
    import flpst_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_slot_req  i_req,
    output logic [63:0]     o_rdata
);

    logic [63:0]           mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;
    logic [63:0]           r_rdata;
    logic                  r_rvld;

    // Storage array and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    // Valid bits: a page erase clears them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.clear_all) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rvld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : SLOT_ERASED;

endmodule
`default_nettype wire

@@ hw/rtl/flpst_ctrl.sv @@
// ----------------------------------------------------------------------------
// flpst_ctrl
// Sequencer that scans, updates and compacts the slot page for one item,
// holding the compaction buffer.
// ----------------------------------------------------------------------------
`default_nettype none
module flpst_ctrl
    import flpst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_cmd,
    input  wire logic [6:0]  i_word_index,
    input  wire logic [3:0]  i_byte_mask,
    input  wire logic [31:0] i_write_data,
    input  wire logic [7:0]  i_words_in_use,
    input  wire logic        i_take,
    input  wire logic [63:0] i_rdata,
    output logic             o_idle,
    output logic             o_res_valid,
    output t_result          o_res,
    output t_slot_req        o_req
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_REQ  = 4'd1;
    localparam logic [3:0] ST_RD_CHK  = 4'd2;
    localparam logic [3:0] ST_W1_REQ  = 4'd3;
    localparam logic [3:0] ST_W1_CHK  = 4'd4;
    localparam logic [3:0] ST_W1_END  = 4'd5;
    localparam logic [3:0] ST_AP_REQ  = 4'd6;
    localparam logic [3:0] ST_AP_CHK  = 4'd7;
    localparam logic [3:0] ST_CM_REQ  = 4'd8;
    localparam logic [3:0] ST_CM_CHK  = 4'd9;
    localparam logic [3:0] ST_CLR     = 4'd10;
    localparam logic [3:0] ST_CP_REQ  = 4'd11;
    localparam logic [3:0] ST_CP_WR   = 4'd12;
    localparam logic [3:0] ST_DONE    = 4'd13;

    localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOT_COUNT - 1);

    logic [3:0]          r_state;
    logic [SLOT_AW-1:0]  r_idx;
    logic [CB_AW:0]      r_cnt;
    logic [15:0]         r_key;
    logic [31:0]         r_lanes;
    logic [31:0]         r_wdata;
    logic                r_found;
    logic [SLOT_AW-1:0]  r_fit;
    logic [31:0]         r_old;
    logic [63:0]         r_tuple;
    t_result             r_res;
    logic [63:0]         cbuf [MAX_WORDS];
    logic [63:0]         r_cbd;

    logic                v_erased;
    logic                v_dead;
    logic                v_cons;
    logic                v_match;
    logic [31:0]         merged;

    assign v_erased = (i_rdata == SLOT_ERASED);
    assign v_dead   = (i_rdata == SLOT_DEAD);
    assign v_cons   = slot_consistent(i_rdata);
    assign v_match  = v_cons && (i_rdata[47:32] == r_key);
    assign merged   = (r_old & ~r_lanes) | (r_wdata & r_lanes);

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    // Slot memory requests for each step of the sequence.
    always_comb begin
        o_req = '0;
        o_req.addr = r_idx;
        case (r_state)
            ST_RD_REQ, ST_W1_REQ, ST_AP_REQ, ST_CM_REQ: begin
                o_req.rd_en = 1'b1;
            end
            ST_W1_CHK: begin
                if (!v_erased && !v_dead) begin
                    if (!v_cons) begin
                        o_req.wr_en = 1'b1;
                    end else if (v_match && r_found) begin
                        o_req.wr_en = 1'b1;
                        o_req.addr  = r_fit;
                    end
                end
            end
            ST_W1_END: begin
                if (r_found && ((r_old & r_lanes) != (r_wdata & r_lanes))) begin
                    o_req.wr_en = 1'b1;
                    o_req.addr  = r_fit;
                end
            end
            ST_AP_CHK: begin
                if (v_erased) begin
                    o_req.wr_en = 1'b1;
                    o_req.wdata = r_tuple;
                end
            end
            ST_CLR: begin
                o_req.clear_all = 1'b1;
            end
            ST_CP_WR: begin
                o_req.wr_en = 1'b1;
                o_req.wdata = r_cbd;
            end
            default: begin
            end
        endcase
    end

    // Compaction buffer, written and read in clocked logic.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_W1_END) begin
            cbuf[0] <= {~r_key, r_key, merged};
        end else if (r_state == ST_CM_CHK && !v_erased && !v_dead && v_cons
                     && !r_cnt[CB_AW]) begin
            cbuf[r_cnt[CB_AW-1:0]] <= i_rdata;
        end
        if (r_state == ST_CP_REQ) begin
            r_cbd <= cbuf[r_idx[CB_AW-1:0]];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_key   <= {7'd0, i_word_index, 2'b00};
                        r_lanes <= lane_mask(i_byte_mask);
                        r_wdata <= i_write_data;
                        r_found <= 1'b0;
                        r_old   <= '0;
                        r_idx   <= '0;
                        r_res   <= '0;
                        if (!i_words_in_use[7] && ({1'b0, i_word_index} >= i_words_in_use))
                        begin
                            r_res.status    <= 1'b1;
                            r_res.read_data <= '1;
                            r_state         <= ST_DONE;
                        end else if (!i_cmd) begin
                            r_state <= ST_RD_REQ;
                        end else if (i_byte_mask == 4'd0) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_W1_REQ;
                        end
                    end
                end
                ST_RD_REQ: r_state <= ST_RD_CHK;
                ST_RD_CHK: begin
                    if (v_match) begin
                        r_res.read_data <= (i_rdata[31:0] & r_lanes) | ~r_lanes;
                        r_state         <= ST_DONE;
                    end else if (r_idx == LAST_SLOT) begin
                        r_res.read_data <= '1;
                        r_state         <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_RD_REQ;
                    end
                end
                ST_W1_REQ: r_state <= ST_W1_CHK;
                ST_W1_CHK: begin
                    if (!v_erased && !v_dead && v_match) begin
                        r_found <= 1'b1;
                        r_fit   <= r_idx;
                        r_old   <= i_rdata[31:0];
                    end
                    if (r_idx == LAST_SLOT) begin
                        r_state <= ST_W1_END;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_W1_REQ;
                    end
                end
                ST_W1_END: begin
                    r_tuple <= {~r_key, r_key, merged};
                    r_idx   <= '0;
                    if (r_found && ((r_old & r_lanes) == (r_wdata & r_lanes))) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_res.appended <= 1'b1;
                        r_state        <= ST_AP_REQ;
                    end
                end
                ST_AP_REQ: r_state <= ST_AP_CHK;
                ST_AP_CHK: begin
                    if (v_erased) begin
                        r_state <= ST_DONE;
                    end else if (r_idx == LAST_SLOT) begin
                        r_idx   <= '0;
                        r_cnt   <= (CB_AW+1)'(1);
                        r_state <= ST_CM_REQ;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_AP_REQ;
                    end
                end
                ST_CM_REQ: r_state <= ST_CM_CHK;
                ST_CM_CHK: begin
                    if (!v_erased && !v_dead && v_cons && !r_cnt[CB_AW]) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_idx == LAST_SLOT) begin
                        r_state <= ST_CLR;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_CM_REQ;
                    end
                end
                ST_CLR: begin
                    r_idx   <= '0;
                    r_state <= ST_CP_REQ;
                end
                ST_CP_REQ: r_state <= ST_CP_WR;
                ST_CP_WR: begin
                    if ((SLOT_AW+1)'(r_idx) + 1'b1 == (SLOT_AW+1)'(r_cnt)) begin
                        r_res.compacted <= 1'b1;
                        r_state         <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_CP_REQ;
                    end
                end
                ST_DONE: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/flash_log_parameter_store.sv @@
// ----------------------------------------------------------------------------
// flash_log_parameter_store
// Parameter words kept as a log of tuples in one emulated flash page.
// ----------------------------------------------------------------------------
// Usage: command items enter on the s-side stream (tuser = cmd, 0 read,
// 1 write); one result item leaves on the m-side stream for each of them.
// The register words_in_use is written through i_cfg_we / i_cfg_wdata.
// Throughput: one item at a time. A read scans the page slot by slot until
// the key is found or the last slot is read. A write scans all 256 slots,
// searches for an erased slot and, on a full page, runs a compaction pass
// that gathers the surviving tuples and writes them back after a page
// erase. The slot memory has a single port and a registered read. An
// out-of-range index or an empty write mask finishes without a page scan.
// Reset: every slot reads as erased at once (valid bits are cleared), and
// words_in_use returns to 64; no clearing pass is needed.
// Stall: a result waits in the output register; the next item may be
// accepted meanwhile, and the sequencer holds its next result until the
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module flash_log_parameter_store
    import flpst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tdata: word_index[6:0], byte_mask[10:7], write_data[42:11], zero fill
    input  wire logic [47:0] i_s_tdata,
    // tuser: cmd
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata: status[0], read_data[32:1], appended[33], compacted[34], zero fill
    output logic [39:0]      o_m_tdata
);

    logic [7:0] r_wiu;
    logic       r_ov;
    t_result    r_out;
    logic       idle;
    logic       res_valid;
    logic       take;
    t_result    res;
    t_slot_req  req;
    logic [63:0] rdata;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiu <= 8'd64;
        end else if (i_cfg_we) begin
            r_wiu <= i_cfg_wdata;
        end
    end

    assign o_s_tready = idle;
    assign take       = res_valid && (!r_ov || i_m_tready);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (take) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'd0, r_out};

    flpst_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_s_tvalid && idle),
        .i_cmd          (i_s_tuser),
        .i_word_index   (i_s_tdata[6:0]),
        .i_byte_mask    (i_s_tdata[10:7]),
        .i_write_data   (i_s_tdata[42:11]),
        .i_words_in_use (r_wiu),
        .i_take         (take),
        .i_rdata        (rdata),
        .o_idle         (idle),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .o_req          (req)
    );

    flpst_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (rdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/flpst_checker.sv @@
// ----------------------------------------------------------------------------
// flpst_checker
// Port-level assertions for the flash log parameter store.
// ----------------------------------------------------------------------------
`default_nettype none
module flpst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    // A result held back by the receiver keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // An accepted item keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("accepted a second item at once");

    // An out-of-range result carries all ones and no flags.
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |->
            o_m_tdata[34:33] == 2'b00 && o_m_tdata[32:1] == 32'hffffffff)
        else $error("bad out-of-range result");

    // A compaction only happens for a write that appended.
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[34] |-> o_m_tdata[33] && o_m_tdata[32:1] == 32'd0)
        else $error("compaction without append");

endmodule

bind flash_log_parameter_store flpst_checker u_flpst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
